>>> sv/sldd_pkg.sv
// Shared types and constants for the sync/length/id deframer.
// No dependencies; imported by the core, output buffer and top level.
package sldd_pkg;

  // default number of bytes in the little-endian length field
  localparam int LENGTH_BYTES_DEF = 2;

  localparam int SYNC_W   = 32;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 16;
  localparam int OUT_DW   = 56;  // 49 field bits padded to whole bytes
  localparam int OUT_UW   = 3;

  // one result beat
  typedef struct packed {
    logic               sync_found;
    logic               length_error;
    logic               data_valid;
    logic [BYTE_W-1:0]  data_out;
    logic [COUNT_W-1:0] data_offset;
    logic               packet_done;
    logic [BYTE_W-1:0]  packet_id;
    logic [COUNT_W-1:0] payload_length;
    logic               count_exhausted;
  } sldd_result_t;

endpackage

>>> sv/sldd_core.sv
// Deframer state and per-byte update logic; produces one result per step.
// Depends on sldd_pkg.
module sldd_core #(
  parameter int LENGTH_BYTES = sldd_pkg::LENGTH_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          req_restart,
  input  logic [sldd_pkg::BYTE_W-1:0]   rx_byte,
  input  logic                          cfg_we,
  input  logic [sldd_pkg::SYNC_W-1:0]   cfg_sync_word,
  output sldd_pkg::sldd_result_t        res
);
  import sldd_pkg::*;

  localparam logic [1:0] PH_SYNC = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_ID   = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  localparam int KW = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;

  logic [SYNC_W-1:0]  sync_word_r;
  logic [1:0]         phase_r, phase_nxt;
  logic [SYNC_W-1:0]  pattern_r, pattern_nxt;
  logic [COUNT_W-1:0] length_r, length_nxt;
  logic [COUNT_W-1:0] remain_r, remain_nxt;
  logic [BYTE_W-1:0]  id_r, id_nxt;
  logic [COUNT_W-1:0] offset_r, offset_nxt;
  logic               ovf_r, ovf_nxt;

  logic [COUNT_W-1:0] remain_dec;
  logic [COUNT_W-1:0] k_full;
  logic [KW-1:0]      k;
  logic               finished;

  // position within the length field and the decremented count
  assign remain_dec = remain_r - 16'd1;
  assign k_full     = COUNT_W'(LENGTH_BYTES) - remain_r;
  assign k          = k_full[KW-1:0];
  assign finished   = (remain_r == '0) && (phase_r != PH_SYNC);

  // next state and result flags for one beat
  always_comb begin
    phase_nxt   = phase_r;
    pattern_nxt = pattern_r;
    length_nxt  = length_r;
    remain_nxt  = remain_r;
    id_nxt      = id_r;
    offset_nxt  = offset_r;
    ovf_nxt     = ovf_r;
    res         = '0;
    if (req_restart) begin
      offset_nxt = '0;
      length_nxt = '0;
      id_nxt     = '0;
      phase_nxt  = PH_SYNC;
    end else if (!finished) begin
      case (phase_r)
        PH_SYNC: begin
          pattern_nxt = {rx_byte, pattern_r[SYNC_W-1:BYTE_W]};
          if (pattern_nxt == sync_word_r) begin
            phase_nxt      = PH_LEN;
            remain_nxt     = COUNT_W'(LENGTH_BYTES);
            res.sync_found = 1'b1;
          end
        end
        PH_LEN: begin
          if (k == '0) begin
            length_nxt = '0;
            ovf_nxt    = 1'b0;
          end
          // only the two low bytes hold length bits, higher ones saturate
          if ((k >> 1) == '0) begin
            if (k[0]) length_nxt[15:8] = length_nxt[15:8] | rx_byte;
            else      length_nxt[7:0]  = length_nxt[7:0] | rx_byte;
          end else if (rx_byte != '0) begin
            ovf_nxt = 1'b1;
          end
          remain_nxt = remain_dec;
          if (remain_dec == '0) begin
            if (ovf_nxt) length_nxt = '1;
            if (length_nxt == '0) begin
              phase_nxt        = PH_SYNC;
              res.length_error = 1'b1;
            end else begin
              remain_nxt = length_nxt;
              phase_nxt  = PH_ID;
            end
          end
        end
        PH_ID: begin
          id_nxt     = rx_byte;
          remain_nxt = remain_dec;
          if (remain_dec == '0) res.packet_done = 1'b1;
          else                  phase_nxt = PH_DATA;
        end
        default: begin
          res.data_valid  = 1'b1;
          res.data_out    = rx_byte;
          res.data_offset = offset_r;
          offset_nxt      = offset_r + 16'd1;
          remain_nxt      = remain_dec;
          if (remain_dec == '0) res.packet_done = 1'b1;
        end
      endcase
    end
    res.packet_id       = id_nxt;
    res.payload_length  = (length_nxt == '0) ? '0 : (length_nxt - 16'd1);
    res.count_exhausted = (remain_nxt == '0);
  end

  // state update on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SYNC;
      pattern_r <= '0;
      length_r  <= '0;
      remain_r  <= '0;
      id_r      <= '0;
      offset_r  <= '0;
      ovf_r     <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      pattern_r <= pattern_nxt;
      length_r  <= length_nxt;
      remain_r  <= remain_nxt;
      id_r      <= id_nxt;
      offset_r  <= offset_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  // sync word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r <= '0;
    end else if (cfg_we) begin
      sync_word_r <= cfg_sync_word;
    end
  end

  // a restart always lands in the syncing phase
  a_restart_sync: assert property (@(posedge clk) disable iff (!rst_n)
    step && req_restart |=> phase_r == PH_SYNC)
    else $error("restart did not return to syncing");

  // a sync match loads the length field count
  a_sync_loads: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.sync_found |=> remain_r == COUNT_W'(LENGTH_BYTES) && phase_r == PH_LEN)
    else $error("sync match did not start length field");

  // a finished packet leaves no bytes to read
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.packet_done |=> remain_r == '0 && phase_r != PH_SYNC)
    else $error("packet done with bytes remaining");

endmodule

>>> sv/sldd_obuf.sv
// Two-entry output register with skid stage for result beats.
// Depends on sldd_pkg.
module sldd_obuf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  sldd_pkg::sldd_result_t push_data,
  output logic                   push_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sldd_pkg::sldd_result_t out_data
);
  import sldd_pkg::*;

  logic         main_valid_r;
  logic         skid_valid_r;
  sldd_result_t main_data_r;
  sldd_result_t skid_data_r;
  logic         pop;

  assign pop        = main_valid_r && out_ready;
  assign push_ready = !skid_valid_r;
  assign out_valid  = main_valid_r;
  assign out_data   = main_data_r;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) skid_valid_r <= 1'b0;
    end else if (push) begin
      if (!main_valid_r || pop) main_valid_r <= 1'b1;
      else                      skid_valid_r <= 1'b1;
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) main_data_r <= skid_data_r;
    end else if (push) begin
      if (!main_valid_r || pop) main_data_r <= push_data;
      else                      skid_data_r <= push_data;
    end
  end

  // the skid stage is only used behind a full main stage
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid stage holds a beat with main stage empty");

  // a beat in the skid stage moves up on a pop
  a_skid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && pop |=> main_valid_r && !skid_valid_r)
    else $error("skid beat lost on pop");

  // a push with nothing leaving fills a stage
  a_push_kept: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_ready && !pop |=> main_valid_r && (skid_valid_r || !$past(main_valid_r)))
    else $error("pushed beat not stored");

endmodule

>>> sv/sync_length_id_deframer_top.sv
// Top level of the sync/length/id deframer: stream ports and beat packing.
// Depends on sldd_pkg, sldd_core and sldd_obuf.
//
// Usage: each input beat carries one received byte (in_tuser = 0) or a
// restart command (in_tuser = 1). The block hunts for the 32-bit sync word
// written on the cfg channel, reads a little-endian length field, one ID
// byte and then length minus one payload bytes, streaming each payload byte
// out with its offset. Every input beat gives exactly one output beat.
// The result of a beat is registered in the output buffer before it is shown on out_*.
// Throughput: one beat per cycle while in_tready is high; the per-byte
// update is a single pass of a 32-bit compare and a 16-bit decrement
// between the state registers and the output register.
// Stalls: a skid stage behind the output register keeps in_tready high while
// one result waits; in_tready drops only when both stages are full.
// Reset: synchronous active-low rst_n clears the deframer state and the sync
// word to zero; there is no clearing pass and cfg_ready is always high.
// The user must write the sync word only while the block is idle; the block does not enforce it.
module sync_length_id_deframer_top #(
  parameter int LENGTH_BYTES = sldd_pkg::LENGTH_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] rx_byte
  input  logic                          in_tuser,   // [0] req_type
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] data_out, [23:8] data_offset, [31:24] packet_id,
  // [47:32] payload_length, [48] count_exhausted, [55:49] zero
  output logic [sldd_pkg::OUT_DW-1:0]   out_tdata,
  // [0] sync_found, [1] length_error, [2] data_valid
  output logic [sldd_pkg::OUT_UW-1:0]   out_tuser,
  output logic                          out_tlast,  // packet_done
  // configuration: sync word
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sldd_pkg::SYNC_W-1:0]   cfg_data
);
  import sldd_pkg::*;

  logic         in_accept;
  sldd_result_t step_res;
  sldd_result_t out_res;

  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  sldd_core #(
    .LENGTH_BYTES(LENGTH_BYTES)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_accept),
    .req_restart  (in_tuser),
    .rx_byte      (in_tdata),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_sync_word(cfg_data),
    .res          (step_res)
  );

  sldd_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (step_res),
    .push_ready(in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  // result beat packing
  assign out_tdata = {7'd0, out_res.count_exhausted, out_res.payload_length,
                      out_res.packet_id, out_res.data_offset, out_res.data_out};
  assign out_tuser = {out_res.data_valid, out_res.length_error, out_res.sync_found};
  assign out_tlast = out_res.packet_done;

endmodule
